[hw/rtl/ghpc_pkg.sv]
`default_nettype none
package ghpc_pkg;

  // Datapath widths fixed by the item fields and the largest grid (64 x 64).
  localparam int CNT_W     = 7;   // grid point counts up to 64
  localparam int POS_W     = 22;  // grid position, cell index and Q16 fraction
  localparam int FRAC_W    = 17;  // fraction including the value 65536
  localparam int DIV_NUM_W = 44;  // dividend bits of the serial divider
  localparam int DIV_DEN_W = 24;  // divisor bits of the serial divider
  localparam int DIV_CNT_W = 6;
  localparam int ACC_W     = 60;  // interpolated height scaled by 2^32
  localparam int PROD_W    = 43;  // 25 x 18 signed product
  localparam int P16_W     = 20;  // palette position, four integer bits

  localparam logic [DIV_CNT_W-1:0] POS_ITER  = DIV_CNT_W'(32);
  localparam logic [DIV_CNT_W-1:0] NORM_ITER = DIV_CNT_W'(44);

  typedef enum logic [2:0] {
    CFG_GRID_ROWS   = 3'd0,
    CFG_GRID_COLS   = 3'd1,
    CFG_PLOT_WIDTH  = 3'd2,
    CFG_PLOT_HEIGHT = 3'd3,
    CFG_MIN_HALF    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QSTART,
    OP_COL_DONE,
    OP_ROW_DONE,
    OP_RD,
    OP_LO,
    OP_HI,
    OP_NORM1,
    OP_NORM2,
    OP_P_DONE,
    OP_BLEND
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL_DIV,
    S_ROW_DIV,
    S_RD,
    S_LO,
    S_HI,
    S_ACC,
    S_NORM1,
    S_NORM2,
    S_P_DIV,
    S_BLEND,
    S_BLEND_WAIT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_LO,
    TAG_HI,
    TAG_CH
  } tag_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // Eleven-stop diverging palette, packed as {red, green, blue}.
  function automatic logic [23:0] stop_rgb(input logic [3:0] s);
    logic [23:0] v;
    unique case (s)
      4'd0:    v = 24'h313695;
      4'd1:    v = 24'h4575b4;
      4'd2:    v = 24'h74add1;
      4'd3:    v = 24'habd9e9;
      4'd4:    v = 24'he0f3f8;
      4'd5:    v = 24'hffffbf;
      4'd6:    v = 24'hfee090;
      4'd7:    v = 24'hfdae61;
      4'd8:    v = 24'hf46d43;
      4'd9:    v = 24'hd73027;
      4'd10:   v = 24'ha50026;
      default: v = 24'h000000;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_ch(input logic [23:0] rgb, input logic [1:0] ch);
    logic [7:0] v;
    unique case (ch)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/grid_heatmap_pixel_color.sv]
`default_nettype none
// Mesh heat-map pixel color. Raise start with cmd 0 to load one height sample
// (grid_row, grid_col, height); busy stays low during a load and the
// block takes another item in the very next cycle. A sample at row 0 column 0
// restarts the peak-magnitude tracker. Raise start with cmd 1 to ask for the
// color of pixel (pixel_x, pixel_y); busy then stays high until the color is
// ready, and the palette division is skipped when the half range is zero or
// the height lies at or beyond an end of the scale. The next item can be taken
// once busy is low again. The color is on red, green and blue while done is
// high, in the last of the busy cycles. The receiver cannot stall: the result
// must be taken in that cycle. A query uses the single serial divider, which
// produces one quotient bit per cycle, for the column and row positions and
// then the palette position, each division followed by a step that takes the
// quotient. The four corner reads and multiplies run on the shared
// multiplier, followed by the normalization and then the blend of the three
// channels, which ends with the result cycle.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// and must only be changed while the block is idle; cfg_ready is always high.
// Unwritten height entries read back as undefined values.
module grid_heatmap_pixel_color
  import ghpc_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd,
  input  wire logic [3:0]  grid_row,
  input  wire logic [3:0]  grid_col,
  input  wire logic [23:0] height,
  input  wire logic [9:0]  pixel_x,
  input  wire logic [9:0]  pixel_y,
  output logic             done,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t stat;
  logic     start_ok;

  // Writes are plain register updates, so the port never holds off.
  assign cfg_ready = 1'b1;
  // Items are only taken while the controller is idle.
  assign start_ok  = start && !busy;

  ghpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start_ok),
    .is_query (cmd),
    .stat     (stat),
    .busy     (busy),
    .done     (done),
    .dp_cmd   (dp_cmd)
  );

  ghpc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grid_row  (grid_row),
    .grid_col  (grid_col),
    .height    (height),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
`default_nettype wire

[hw/rtl/ghpc_ctrl.sv]
`default_nettype none
module ghpc_ctrl
  import ghpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     is_query,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          done,
  output dp_cmd_t       dp_cmd
);

  state_t     state, state_next;
  logic [1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= 2'd0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (start && is_query) begin
          state_next = S_COL_DIV;
        end
      end
      S_COL_DIV: begin
        if (stat.div_done) begin
          state_next = S_ROW_DIV;
        end
      end
      S_ROW_DIV: begin
        if (stat.div_done) begin
          state_next = S_RD;
          k_next     = 2'd0;
        end
      end
      S_RD: state_next = S_LO;
      S_LO: state_next = S_HI;
      S_HI: begin
        if (k == 2'd3) begin
          state_next = S_ACC;
        end else begin
          state_next = S_RD;
          k_next     = k + 2'd1;
        end
      end
      S_ACC:   state_next = S_NORM1;
      S_NORM1: state_next = S_NORM2;
      S_NORM2: state_next = S_P_DIV;
      S_P_DIV: begin
        if (stat.div_done) begin
          state_next = S_BLEND;
          k_next     = 2'd0;
        end
      end
      S_BLEND: begin
        if (k == 2'd2) begin
          state_next = S_BLEND_WAIT;
        end else begin
          k_next = k + 2'd1;
        end
      end
      S_BLEND_WAIT: state_next = S_FIN;
      S_FIN:        state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != S_IDLE);
    done       = (state == S_FIN);
    dp_cmd.op  = OP_NONE;
    dp_cmd.idx = k;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          dp_cmd.op = is_query ? OP_QSTART : OP_LOAD;
        end
      end
      S_COL_DIV: if (stat.div_done) dp_cmd.op = OP_COL_DONE;
      S_ROW_DIV: if (stat.div_done) dp_cmd.op = OP_ROW_DONE;
      S_RD:      dp_cmd.op = OP_RD;
      S_LO:      dp_cmd.op = OP_LO;
      S_HI:      dp_cmd.op = OP_HI;
      S_NORM1:   dp_cmd.op = OP_NORM1;
      S_NORM2:   dp_cmd.op = OP_NORM2;
      S_P_DIV:   if (stat.div_done) dp_cmd.op = OP_P_DONE;
      S_BLEND:   dp_cmd.op = OP_BLEND;
      default:   dp_cmd.op = OP_NONE;
    endcase
  end

  // A query that is taken must make the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_query) |=> busy)
    else $error("query accepted but controller stayed idle");

  // A result strobe is a single cycle and returns the block to idle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // The corner loop only runs once the row division has finished.
  a_rd_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && k == 2'd0) |-> ($past(state) == S_ROW_DIV))
    else $error("corner loop entered out of order");

endmodule
`default_nettype wire

[hw/rtl/ghpc_dp.sv]
`default_nettype none
module ghpc_dp
  import ghpc_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     dp_cmd,
  output dp_stat_t         stat,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_data,
  input  wire logic [3:0]  grid_row,
  input  wire logic [3:0]  grid_col,
  input  wire logic [23:0] height,
  input  wire logic [9:0]  pixel_x,
  input  wire logic [9:0]  pixel_y,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_COLS);

  // Configuration registers.
  logic [4:0]  grid_rows, grid_cols;
  logic [9:0]  plot_width, plot_height;
  logic [22:0] min_half_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows      <= 5'd1;
      grid_cols      <= 5'd1;
      plot_width     <= 10'd200;
      plot_height    <= 10'd200;
      min_half_range <= 23'd3277;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_ROWS:   grid_rows      <= cfg_data[4:0];
        CFG_GRID_COLS:   grid_cols      <= cfg_data[4:0];
        CFG_PLOT_WIDTH:  plot_width     <= cfg_data[9:0];
        CFG_PLOT_HEIGHT: plot_height    <= cfg_data[9:0];
        CFG_MIN_HALF:    min_half_range <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample loads and the peak tracker.
  logic [CNT_W-1:0] row_ext, col_ext;
  logic             load_ok;
  logic [23:0]      mag;
  logic [23:0]      peak;

  assign row_ext = {3'b000, grid_row};
  assign col_ext = {3'b000, grid_col};
  assign load_ok = (dp_cmd.op == OP_LOAD) && (row_ext < MAXR) && (col_ext < MAXC);
  assign mag     = height[23] ? 24'(-height) : height;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= 24'd0;
    end else if (load_ok) begin
      if ((grid_row == 4'd0 && grid_col == 4'd0) || mag > peak) begin
        peak <= mag;
      end
    end
  end

  // Query setup: clamp counts, plot size and coordinates.
  logic [CNT_W-1:0] rows_c, cols_c, rows_r, cols_r;
  logic [9:0]       pw_c, ph_c, xs_c, ys_c, yd_c, ph_r;
  logic [16:0]      col_prod;

  always_comb begin
    if (grid_rows == 5'd0)             rows_c = CNT_W'(1);
    else if ({2'b00, grid_rows} > MAXR) rows_c = MAXR;
    else                                rows_c = {2'b00, grid_rows};
    if (grid_cols == 5'd0)             cols_c = CNT_W'(1);
    else if ({2'b00, grid_cols} > MAXC) cols_c = MAXC;
    else                                cols_c = {2'b00, grid_cols};
    pw_c     = (plot_width < 10'd2) ? 10'd2 : plot_width;
    ph_c     = (plot_height < 10'd2) ? 10'd2 : plot_height;
    xs_c     = (pixel_x > pw_c) ? pw_c : pixel_x;
    ys_c     = (pixel_y > ph_c) ? ph_c : pixel_y;
    yd_c     = ph_c - ys_c;
    col_prod = 17'(xs_c * (cols_c - CNT_W'(1)));
  end

  // Grid position decode from the divider quotient.
  logic [DIV_NUM_W-1:0] div_num;
  logic [POS_W-1:0]     pos;
  logic [CNT_W-1:0]     n_sel;
  logic                 pos_clamp, n_single;
  logic [5:0]           idx_sel;
  logic [FRAC_W-1:0]    frac_sel;
  logic [15:0]          row_prod;
  logic [15:0]          row_prod_r;

  always_comb begin
    pos       = div_num[POS_W-1:0];
    n_sel     = (dp_cmd.op == OP_COL_DONE) ? cols_r : rows_r;
    n_single  = (n_sel < CNT_W'(2));
    pos_clamp = ({1'b0, pos[21:16]} > (n_sel - CNT_W'(2)));
    if (n_single) begin
      idx_sel  = 6'd0;
      frac_sel = '0;
    end else if (pos_clamp) begin
      idx_sel  = 6'(n_sel - CNT_W'(2));
      frac_sel = 17'h10000;
    end else begin
      idx_sel  = pos[21:16];
      frac_sel = {1'b0, pos[15:0]};
    end
    row_prod = 16'(yd_c * (rows_c - CNT_W'(1)));
  end

  // Serial restoring divider, one quotient bit per cycle.
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_DEN_W:0]   div_rem, rem_sh;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 q_bit;

  assign rem_sh = {div_rem[DIV_DEN_W-1:0], div_num[DIV_NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_den});
  assign stat.div_done = (div_cnt == '0);

  // Corner coordinates and weights.
  logic [RW-1:0]     r0, r1;
  logic [CW-1:0]     c0, c1;
  logic [FRAC_W-1:0] tc, tr, wc, wr;
  logic [AW-1:0]     raddr;

  always_comb begin
    wc    = dp_cmd.idx[0] ? tc : (17'h10000 - tc);
    wr    = dp_cmd.idx[1] ? tr : (17'h10000 - tr);
    raddr = {dp_cmd.idx[1] ? r1 : r0, dp_cmd.idx[0] ? c1 : c0};
  end

  // Height store: one write port, one registered read port.
  logic signed [23:0] store [0:(2**AW)-1];
  logic signed [23:0] rdata;

  always_ff @(posedge clk) begin
    if (load_ok) begin
      store[{row_ext[RW-1:0], col_ext[CW-1:0]}] <= height;
    end
    rdata <= store[raddr];
  end

  // Palette position and segment.
  logic [P16_W-1:0]  p16;
  logic [3:0]        seg;
  logic [FRAC_W-1:0] f;
  logic [23:0]       rgb_a, rgb_b;
  logic [7:0]        ca, cb, ta;
  logic [1:0]        tag_ch;
  tag_t              tag;

  always_comb begin
    if (p16[19:16] > 4'd9) begin
      seg = 4'd9;
      f   = 17'h10000;
    end else begin
      seg = p16[19:16];
      f   = {1'b0, p16[15:0]};
    end
    rgb_a = stop_rgb(seg);
    rgb_b = stop_rgb(seg + 4'd1);
    ca    = pick_ch(rgb_a, dp_cmd.idx);
    cb    = pick_ch(rgb_b, dp_cmd.idx);
    ta    = pick_ch(rgb_a, tag_ch);
  end

  // Shared multiplier.
  logic signed [24:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [32:0]              wreg;

  always_comb begin
    unique case (dp_cmd.op)
      OP_RD: begin
        mul_a = $signed({8'b0, wc});
        mul_b = $signed({1'b0, wr});
      end
      OP_LO: begin
        mul_a = $signed({rdata[23], rdata});
        mul_b = $signed({1'b0, prod[16:0]});
      end
      OP_HI: begin
        mul_a = $signed({rdata[23], rdata});
        mul_b = $signed({2'b00, wreg[32:17]});
      end
      OP_BLEND: begin
        mul_a = 25'($signed({1'b0, cb}) - $signed({1'b0, ca}));
        mul_b = $signed({1'b0, f});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Normalization terms.
  logic signed [ACC_W-1:0] acc, n_r;
  logic [23:0]             zref_r, zref_c;
  logic [ACC_W-1:0]        n5;
  logic [26:0]             ch_sum;
  logic                    div_used;

  assign zref_c = (peak > {1'b0, min_half_range}) ? peak : {1'b0, min_half_range};
  assign n5     = {n_r[ACC_W-3:0], 2'b00} + n_r;
  assign ch_sum = {3'b000, ta, 16'b0} + {prod[25], prod[25:0]} + 27'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
      tag     <= TAG_NONE;
    end else begin
      tag <= (dp_cmd.op == OP_LO) ? TAG_LO :
             (dp_cmd.op == OP_HI) ? TAG_HI :
             (dp_cmd.op == OP_BLEND) ? TAG_CH : TAG_NONE;
      if (dp_cmd.op == OP_QSTART || dp_cmd.op == OP_COL_DONE) begin
        div_cnt <= POS_ITER;
      end else if (dp_cmd.op == OP_NORM2) begin
        div_cnt <= (zref_r != '0 && n_r > 0 && n_r < $signed({3'b000, zref_r, 33'b0}))
                   ? NORM_ITER : '0;
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    tag_ch <= dp_cmd.idx;
    if (div_cnt != '0) begin
      div_rem <= q_bit ? (rem_sh - {1'b0, div_den}) : rem_sh;
      div_num <= {div_num[DIV_NUM_W-2:0], q_bit};
    end
    unique case (tag)
      TAG_LO:  acc <= acc + ACC_W'(prod);
      TAG_HI:  acc <= acc + (ACC_W'(prod) <<< 17);
      TAG_CH: begin
        unique case (tag_ch)
          2'd0:    red   <= ch_sum[23:16];
          2'd1:    green <= ch_sum[23:16];
          default: blue  <= ch_sum[23:16];
        endcase
      end
      default: ;
    endcase
    unique case (dp_cmd.op)
      OP_QSTART: begin
        rows_r  <= rows_c;
        cols_r  <= cols_c;
        ph_r    <= ph_c;
        div_num <= {col_prod[15:0], 28'b0};
        div_den <= {14'b0, pw_c};
        div_rem <= '0;
      end
      OP_COL_DONE: begin
        c0      <= idx_sel[CW-1:0];
        c1      <= n_single ? idx_sel[CW-1:0] : CW'(idx_sel + 6'd1);
        tc      <= frac_sel;
        div_num <= {row_prod_r, 28'b0};
        div_den <= {14'b0, ph_r};
        div_rem <= '0;
      end
      OP_ROW_DONE: begin
        r0  <= idx_sel[RW-1:0];
        r1  <= n_single ? idx_sel[RW-1:0] : RW'(idx_sel + 6'd1);
        tr  <= frac_sel;
        acc <= '0;
      end
      OP_LO:    wreg <= prod[32:0];
      OP_NORM1: begin
        zref_r <= zref_c;
        n_r    <= acc + $signed({4'b0000, zref_c, 32'b0});
      end
      OP_NORM2: begin
        div_used <= 1'b0;
        if (zref_r == '0) begin
          p16 <= P16_W'(5 << 16);
        end else if (n_r <= 0) begin
          p16 <= '0;
        end else if (n_r >= $signed({3'b000, zref_r, 33'b0})) begin
          p16 <= P16_W'(10 << 16);
        end else begin
          div_num  <= n5[ACC_W-1:16];
          div_den  <= zref_r;
          div_rem  <= '0;
          div_used <= 1'b1;
        end
      end
      OP_P_DONE: if (div_used) p16 <= div_num[P16_W-1:0];
      default: ;
    endcase
  end

  // Row dividend is captured at query start, while the pixel ports are valid.
  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_QSTART) begin
      row_prod_r <= row_prod;
    end
  end

endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb
  import ghpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Golden color predictor for the heat-map block together with the queue of
  // colors still owed by the design. Loads update the private copy of the
  // height grid and the peak tracker; queries add one expected color.
  class pixel_scoreboard;
    int store [256];
    int unsigned peak;
    logic [4:0]  rows_reg, cols_reg;
    logic [9:0]  width_reg, height_reg;
    logic [22:0] floor_reg;
    logic [23:0] palette [11];
    logic [23:0] owed_colors [$];
    int errors;
    int colors_seen;

    function new();
      palette = '{24'h313695, 24'h4575b4, 24'h74add1, 24'habd9e9, 24'he0f3f8,
                  24'hffffbf, 24'hfee090, 24'hfdae61, 24'hf46d43, 24'hd73027,
                  24'ha50026};
      foreach (store[i]) store[i] = 0;
      peak = 0;
      rows_reg = 5'd1;
      cols_reg = 5'd1;
      width_reg = 10'd200;
      height_reg = 10'd200;
      floor_reg = 23'd3277;
      errors = 0;
      colors_seen = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_t idx, logic [22:0] data);
      case (idx)
        CFG_GRID_ROWS:   rows_reg = data[4:0];
        CFG_GRID_COLS:   cols_reg = data[4:0];
        CFG_PLOT_WIDTH:  width_reg = data[9:0];
        CFG_PLOT_HEIGHT: height_reg = data[9:0];
        CFG_MIN_HALF:    floor_reg = data;
        default: ;
      endcase
    endfunction

    // Lower grid index and Q16 fraction for a distance d across span.
    function void grid_pos(int unsigned d, int unsigned span, int unsigned n,
                           output int unsigned idx, output int unsigned frac);
      longint unsigned pos;
      if (n < 2) begin
        idx = 0;
        frac = 0;
        return;
      end
      pos = ((64'(d) * 64'(n - 1)) << 16) / 64'(span);
      idx = int'(pos >> 16);
      if (idx > n - 2) idx = n - 2;
      frac = int'(pos - (64'(idx) << 16));
    endfunction

    function logic [23:0] color_of(int unsigned x, int unsigned y);
      int unsigned rows, cols, pw, ph, c0, c1, r0, r1, tc, tr, zref, p16, seg, f;
      int unsigned a, b, v;
      longint top, bot, z, num, full;
      logic [23:0] rgb;
      rows = rows_reg < 1 ? 1 : (rows_reg > 16 ? 16 : rows_reg);
      cols = cols_reg < 1 ? 1 : (cols_reg > 16 ? 16 : cols_reg);
      pw = width_reg < 2 ? 2 : width_reg;
      ph = height_reg < 2 ? 2 : height_reg;
      if (x > pw) x = pw;
      if (y > ph) y = ph;
      grid_pos(x, pw, cols, c0, tc);
      grid_pos(ph - y, ph, rows, r0, tr);
      c1 = cols > 1 ? c0 + 1 : c0;
      r1 = rows > 1 ? r0 + 1 : r0;
      top = longint'(store[r0*16 + c0]) * (longint'(65536) - longint'(tc))
          + longint'(store[r0*16 + c1]) * longint'(tc);
      bot = longint'(store[r1*16 + c0]) * (longint'(65536) - longint'(tc))
          + longint'(store[r1*16 + c1]) * longint'(tc);
      z = top * (longint'(65536) - longint'(tr)) + bot * longint'(tr);
      zref = peak > floor_reg ? peak : floor_reg;
      if (zref == 0) begin
        p16 = 5 << 16;
      end else begin
        num = z + (longint'(zref) << 32);
        full = longint'(zref) << 33;
        if (num <= 0) p16 = 0;
        else if (num >= full) p16 = 10 << 16;
        else p16 = int'((num * 5) / (longint'(zref) << 16));
      end
      seg = p16 >> 16;
      if (seg > 9) seg = 9;
      f = p16 - (seg << 16);
      for (int k = 0; k < 3; k++) begin
        a = palette[seg][23-8*k -: 8];
        b = palette[seg+1][23-8*k -: 8];
        v = (a * (65536 - f) + b * f + 32768) >> 16;
        rgb[23-8*k -: 8] = v[7:0];
      end
      return rgb;
    endfunction

    // Called for every accepted item.
    function void note_item(logic c, logic [3:0] r, logic [3:0] col,
                            logic [23:0] h, logic [9:0] x, logic [9:0] y);
      int hv;
      int unsigned mag;
      if (c == 1'b0) begin
        hv = {{8{h[23]}}, h};
        mag = hv < 0 ? -hv : hv;
        store[r*16 + col] = hv;
        if ((r == 0 && col == 0) || mag > peak) peak = mag;
      end else begin
        owed_colors = {owed_colors, color_of(x, y)};
      end
    endfunction

    task check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [23:0] want;
      colors_seen++;
      if (owed_colors.size() == 0) begin
        report($sformatf("color %02h%02h%02h with no query waiting", r, g, b));
        return;
      end
      want = owed_colors.pop_front();
      if (r !== want[23:16]) report($sformatf("red %02h, expected %02h", r, want[23:16]));
      if (g !== want[15:8]) report($sformatf("green %02h, expected %02h", g, want[15:8]));
      if (b !== want[7:0]) report($sformatf("blue %02h, expected %02h", b, want[7:0]));
    endtask

    function int pending();
      return owed_colors.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = 1'b0;
  logic [3:0]  grid_row = '0;
  logic [3:0]  grid_col = '0;
  logic [23:0] height = '0;
  logic [9:0]  pixel_x = '0;
  logic [9:0]  pixel_y = '0;
  logic        done;
  logic [7:0]  red, green, blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;

  grid_heatmap_pixel_color dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .grid_row(grid_row), .grid_col(grid_col), .height(height),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
    .red(red), .green(green), .blue(blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  pixel_scoreboard sb = new();

  int loads_sent = 0;
  int queries_sent = 0;
  int phases_run = 0;
  bit idle_on = 1'b1;   // random gaps between items; cleared for the final stretch

  // Results cannot be held off, so every done cycle is checked right at the edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_color(red, green, blue);
  end

  // Watchdog: the longest quiet stretch is a query, a gap or the drain
  // before a register write.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 3000) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Present one item at the falling edge and hold it until a rising edge
  // finds busy low. Start stays high so back-to-back items need no gap.
  task automatic issue(logic c, logic [3:0] r, logic [3:0] col, logic [23:0] h,
                       logic [9:0] x, logic [9:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) idle($urandom_range(1, 13));
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    grid_row = r;
    grid_col = col;
    height = h;
    pixel_x = x;
    pixel_y = y;
    do @(posedge clk); while (busy);
    sb.note_item(c, r, col, h, x, y);
    if (c) queries_sent++;
    else loads_sent++;
  endtask

  task automatic load(logic [3:0] r, logic [3:0] col, logic [23:0] h);
    issue(1'b0, r, col, h, 10'($urandom), 10'($urandom));
  endtask

  task automatic query(logic [9:0] x, logic [9:0] y);
    issue(1'b1, 4'($urandom), 4'($urandom), 24'($urandom), x, y);
  endtask

  // Stop sending until every owed color is back, then wait longer so that
  // nothing is in flight when a register changes.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [22:0] data);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Heights: full random, small values near the color floor, or extremes.
  function automatic logic [23:0] pick_height(int style);
    case (style)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 16383) - 8192);
      default: begin
        case ($urandom_range(0, 3))
          0: return 24'h7fffff;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hffffff;
        endcase
      end
    endcase
  endfunction

  // One setting of the registers: program it, fill the grid region in use
  // (row 0 column 0 first, which restarts the peak), then mix random loads
  // and queries. Every store entry a query can touch is written first.
  task automatic run_phase(logic [4:0] rows, logic [4:0] cols, logic [9:0] pw,
                           logic [9:0] ph, logic [22:0] floor_val, int n_items);
    int nr, nc, pws, phs, style;
    nr = rows < 1 ? 1 : (rows > 16 ? 16 : rows);
    nc = cols < 1 ? 1 : (cols > 16 ? 16 : cols);
    pws = pw < 2 ? 2 : pw;
    phs = ph < 2 ? 2 : ph;
    style = $urandom_range(0, 2);
    drain();
    write_reg(CFG_GRID_ROWS, {18'($urandom), rows});
    write_reg(CFG_GRID_COLS, {18'($urandom), cols});
    write_reg(CFG_PLOT_WIDTH, {13'($urandom), pw});
    write_reg(CFG_PLOT_HEIGHT, {13'($urandom), ph});
    write_reg(CFG_MIN_HALF, floor_val);
    phases_run++;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) load(4'(r), 4'(c), pick_height(style));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 9) == 0) query(10'($urandom), 10'($urandom));
        else query(10'($urandom_range(0, pws + 2)), 10'($urandom_range(0, phs + 2)));
      end else if ($urandom_range(0, 15) == 0) begin
        load(4'd0, 4'd0, pick_height($urandom_range(0, 2)));
      end else begin
        load(4'($urandom), 4'($urandom), pick_height($urandom_range(0, 2)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items on the reset setting: one-point grid, full-scale heights
    // of both signs and a small peak under the floor.
    load(4'd0, 4'd0, 24'h7fffff);
    query(10'd0, 10'd0);
    query(10'd1023, 10'd1023);
    load(4'd0, 4'd0, 24'h800000);
    query(10'd100, 10'd100);
    load(4'd5, 4'd7, 24'h000000);
    load(4'd0, 4'd0, 24'h000001);
    query(10'd200, 10'd0);

    // Zero peak and zero floor give the middle of the palette.
    drain();
    write_reg(CFG_MIN_HALF, 23'd0);
    load(4'd0, 4'd0, 24'h000000);
    query(10'd7, 10'd9);

    // A two-by-two grid on the smallest plot; the late small sample at row 0
    // column 0 drops the peak, so the large corners clamp the scale.
    drain();
    write_reg(CFG_GRID_ROWS, 23'd2);
    write_reg(CFG_GRID_COLS, 23'd2);
    write_reg(CFG_PLOT_WIDTH, 23'd2);
    write_reg(CFG_PLOT_HEIGHT, 23'd2);
    write_reg(CFG_MIN_HALF, 23'd1);
    load(4'd0, 4'd1, 24'h7fffff);
    load(4'd1, 4'd0, 24'h800000);
    load(4'd1, 4'd1, 24'h400000);
    load(4'd0, 4'd0, 24'h00000a);
    query(10'd0, 10'd0);
    query(10'd2, 10'd0);
    query(10'd0, 10'd2);
    query(10'd2, 10'd2);
    query(10'd1, 10'd1);
    query(10'd1023, 10'd0);

    // Random part over a spread of settings, extremes and out-of-range
    // register values included.
    run_phase(5'd16, 5'd16, 10'd1023, 10'd1023, 23'h7fffff, 100);
    run_phase(5'd1, 5'd16, 10'd2, 10'd2, 23'd1, 100);
    run_phase(5'd16, 5'd1, 10'd0, 10'd1, 23'd0, 100);
    run_phase(5'd0, 5'd31, 10'd5, 10'd1023, 23'd3277, 100);
    run_phase(5'd2, 5'd2, 10'd37, 10'd511, 23'd100, 100);
    run_phase(5'd17, 5'd3, 10'd200, 10'd200, 23'h7fffff, 100);
    for (int p = 0; p < 3; p++)
      run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                10'($urandom_range(2, 1023)), 10'($urandom_range(2, 1023)),
                23'($urandom_range(1, 8388607)), 80);
    // Final stretch with items back to back.
    idle_on = 1'b0;
    run_phase(5'd4, 5'd5, 10'd63, 10'd300, 23'd5000, 150);

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.pending() > 0) sb.report($sformatf("%0d colors never arrived", sb.pending()));

    $display("covered %0d loads and %0d pixel queries over %0d register settings",
             loads_sent, queries_sent, phases_run);
    $display("%0d colors checked, %0d mismatches", sb.colors_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
